FILE: design/lbspcd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the descriptor change detector.
package lbspcd_pkg;

  localparam int unsigned DESC_BITS = 16;
  localparam int unsigned CHANNELS = 3;
  localparam int unsigned DESC_W = DESC_BITS * CHANNELS;
  localparam int unsigned IMG_W = 8 * CHANNELS;
  localparam int unsigned INDEX_W = 17;
  localparam int unsigned COUNT_W = 18;
  localparam int unsigned DIST_W = 8;
  localparam int unsigned POP_W = 5;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_DETECT = 2'd1;
  localparam logic [1:0] CMD_TRAIN = 2'd2;

  localparam logic [1:0] REG_TOTAL_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_STREAK_LENGTH = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [1:0] REG_FRAME_PIXELS = 2'd3;

  localparam logic [7:0] STREAK_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [INDEX_W-1:0] pixel_index;
    logic [DESC_W-1:0]  desc_now;
    logic [DESC_W-1:0]  desc_second;
    logic [DESC_W-1:0]  desc_third;
    logic [IMG_W-1:0]   image_pixel;
  } in_word_t;

  typedef struct packed {
    logic               foreground;
    logic [COUNT_W-1:0] trained_count;
    logic               model_incomplete;
  } out_word_t;

  typedef struct packed {
    logic [DESC_W-1:0] bg_desc;
    logic [DESC_W-1:0] bg_desc_alt;
    logic [IMG_W-1:0]  bg_image;
    logic [IMG_W-1:0]  bg_image_alt;
    logic [7:0]        bg_streak;
    logic [7:0]        fg_streak;
    logic              stable_flag;
  } pixel_rec_t;

  localparam int unsigned REC_W = $bits(pixel_rec_t);

  typedef struct packed {
    logic [5:0] total_threshold;
    logic [7:0] streak_length;
    logic [1:0] channel_count;
  } det_cfg_t;

  typedef struct packed {
    logic write;
    logic foreground;
    logic count_up;
    logic count_clear;
  } upd_ctrl_t;

  function automatic logic [POP_W-1:0] popcount16(input logic [DESC_BITS-1:0] x);
    logic [2:0] nib [4];
    for (int n = 0; n < 4; n++) begin
      nib[n] = 3'(x[4*n]) + 3'(x[4*n+1]) + 3'(x[4*n+2]) + 3'(x[4*n+3]);
    end
    return (POP_W'(nib[0]) + POP_W'(nib[1])) + (POP_W'(nib[2]) + POP_W'(nib[3]));
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == STREAK_MAX) ? STREAK_MAX : v + 8'd1;
  endfunction

endpackage

FILE: design/lbspcd_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
module lbspcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/lbspcd_update.sv
`timescale 1ns / 1ps
// Per-pixel load, detection and training update: distances, streaks and background adoption.
module lbspcd_update
  import lbspcd_pkg::*;
(
  input  pixel_rec_t rec,
  input  in_word_t   word,
  input  det_cfg_t   cfg,
  input  logic       pix_zero,
  output pixel_rec_t rec_next,
  output upd_ctrl_t  ctrl
);

  logic [1:0]        nch;
  logic              multi;
  logic [11:0]       third_prod;
  logic [POP_W-1:0]  single_thr;
  logic [DESC_W-1:0] dmask;
  logic [IMG_W-1:0]  imask;
  logic [POP_W-1:0]  pc_now [CHANNELS];
  logic [POP_W-1:0]  pc_sec [CHANNELS];
  logic [DIST_W-1:0] d_now;
  logic [DIST_W-1:0] d_sec;
  logic [DIST_W-1:0] thr;
  logic              fg;
  logic [7:0]        fg_inc;
  logic [7:0]        bg_inc;
  pixel_rec_t        r;
  logic              up;

  assign nch = (cfg.channel_count == 2'd0) ? 2'd1 : cfg.channel_count;
  assign multi = (nch > 2'd1);
  assign third_prod = 12'(cfg.total_threshold) * 12'd43;
  assign single_thr = POP_W'(third_prod[11:7]) + POP_W'(1);
  assign thr = DIST_W'(cfg.total_threshold);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      dmask[DESC_BITS*c +: DESC_BITS] = {DESC_BITS{(2'(c) < nch)}};
      imask[8*c +: 8] = {8{(2'(c) < nch)}};
      pc_now[c] = popcount16(word.desc_now[DESC_BITS*c +: DESC_BITS]
                             ^ rec.bg_desc[DESC_BITS*c +: DESC_BITS]);
      pc_sec[c] = popcount16(word.desc_second[DESC_BITS*c +: DESC_BITS]
                             ^ rec.bg_desc_alt[DESC_BITS*c +: DESC_BITS]);
    end
  end

  always_comb begin
    d_now = '0;
    d_sec = '0;
    if (multi) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (2'(c) < nch) begin
          d_now = d_now + ((pc_now[c] >= single_thr) ? thr : DIST_W'(pc_now[c]));
          d_sec = d_sec + ((pc_sec[c] >= single_thr) ? thr : DIST_W'(pc_sec[c]));
        end
      end
    end else begin
      d_now = DIST_W'(pc_now[0]);
      d_sec = DIST_W'(pc_sec[0]);
    end
  end

  assign fg = (d_now >= thr);
  assign fg_inc = sat_inc(rec.fg_streak);
  assign bg_inc = sat_inc(rec.bg_streak);

  always_comb begin
    r = rec;
    up = 1'b0;
    if (fg) begin
      r.fg_streak = fg_inc;
      if (!rec.stable_flag && (fg_inc >= cfg.streak_length)) begin
        r.bg_desc = (rec.bg_desc & ~dmask) | (word.desc_third & dmask);
        r.bg_image = (rec.bg_image & ~imask) | (word.image_pixel & imask);
        r.stable_flag = 1'b1;
        up = 1'b1;
      end
    end else begin
      r.fg_streak = '0;
    end
    if (!r.stable_flag) begin
      if (!fg) begin
        r.bg_streak = bg_inc;
        if (bg_inc >= cfg.streak_length) begin
          r.stable_flag = 1'b1;
          up = 1'b1;
        end
      end else if (d_sec < thr) begin
        r.bg_streak = bg_inc;
        if (bg_inc >= cfg.streak_length) begin
          r.bg_desc = (rec.bg_desc & ~dmask) | (rec.bg_desc_alt & dmask);
          r.bg_image = (rec.bg_image & ~imask) | (rec.bg_image_alt & imask);
          r.stable_flag = 1'b1;
          up = 1'b1;
        end
      end else begin
        r.bg_streak = '0;
        r.bg_desc_alt = (rec.bg_desc_alt & ~dmask) | (word.desc_third & dmask);
        r.bg_image_alt = (rec.bg_image_alt & ~imask) | (word.image_pixel & imask);
      end
    end
  end

  always_comb begin
    rec_next = rec;
    ctrl = '0;
    case (word.cmd)
      CMD_LOAD: begin
        rec_next.bg_desc = word.desc_now;
        rec_next.bg_desc_alt = word.desc_now;
        rec_next.bg_image = word.image_pixel;
        rec_next.bg_image_alt = word.image_pixel;
        rec_next.bg_streak = '0;
        rec_next.fg_streak = '0;
        rec_next.stable_flag = 1'b0;
        ctrl.write = 1'b1;
        ctrl.count_clear = pix_zero;
      end
      CMD_TRAIN: begin
        rec_next = r;
        ctrl.write = 1'b1;
        ctrl.foreground = fg;
        ctrl.count_up = up;
      end
      default: begin
        ctrl.foreground = fg;
      end
    endcase
  end

endmodule

FILE: design/lbsp_change_detect_bg_train_top.sv
`timescale 1ns / 1ps
// Top level of the descriptor change detector with background training.
// The block takes one word per cycle unless the output stalls and returns one
// result word per input word. All per-pixel state (main and alternate background
// descriptors and images, both streak counters and the stable flag) sits in a
// single record memory of MAX_PIXELS entries that is read when a word is accepted
// and written back when that word leaves stage one; a word that hits the pixel
// written back in the same cycle takes the fresh record from a bypass register,
// so any pixel sequence runs at one word per cycle unless the output stalls. Memory
// contents are undefined after reset, so every pixel must be loaded before it is
// detected or trained. Configuration must be written only while the block is idle.
module lbsp_change_detect_bg_train_top
  import lbspcd_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 131072
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  in_word_t     in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output out_word_t    out_data,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_addr,
  input  logic [17:0]  cfg_data
);

  localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam bit POW2 = ((MAX_PIXELS & (MAX_PIXELS - 1)) == 0);

  det_cfg_t           cfg;
  logic [COUNT_W-1:0] frame_pixels;
  logic [COUNT_W-1:0] stable_total;
  logic [COUNT_W-1:0] stable_total_next;

  logic [ADDR_W-1:0]  in_addr;
  logic               in_acc;
  logic               o_ready;

  logic               s1_valid;
  in_word_t           s1_word;
  logic [ADDR_W-1:0]  s1_addr;
  logic               s1_fire;

  logic               byp_valid;
  pixel_rec_t         byp_rec;
  logic [REC_W-1:0]   rd_data;
  pixel_rec_t         s1_rec;
  pixel_rec_t         rec_next;
  upd_ctrl_t          ctrl;

  generate
    if (ADDR_W >= INDEX_W) begin : g_wide
      assign in_addr = ADDR_W'(in_data.pixel_index);
    end else if (POW2) begin : g_mask
      assign in_addr = in_data.pixel_index[ADDR_W-1:0] & ADDR_W'(MAX_PIXELS - 1);
    end else begin : g_reduce
      always_comb begin
        logic [INDEX_W-1:0] v;
        v = in_data.pixel_index;
        for (int k = INDEX_W - 1; k >= 0; k--) begin
          if ((64'(MAX_PIXELS) << k) < (64'd1 << INDEX_W)) begin
            if (64'(v) >= (64'(MAX_PIXELS) << k)) begin
              v = v - INDEX_W'(64'(MAX_PIXELS) << k);
            end
          end
        end
        in_addr = v[ADDR_W-1:0];
      end
    end
  endgenerate

  assign o_ready = !out_valid || !out_stall;
  assign in_stall = s1_valid && !o_ready;
  assign in_acc = in_valid && !in_stall;
  assign s1_fire = s1_valid && o_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_threshold <= 6'd30;
      cfg.streak_length <= 8'd10;
      cfg.channel_count <= 2'd3;
      frame_pixels <= 18'd76800;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_TOTAL_THRESHOLD: cfg.total_threshold <= cfg_data[5:0];
        REG_STREAK_LENGTH:   cfg.streak_length <= cfg_data[7:0];
        REG_CHANNEL_COUNT:   cfg.channel_count <= cfg_data[1:0];
        REG_FRAME_PIXELS:    frame_pixels <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lbspcd_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_PIXELS)
  ) u_rec_ram (
    .clk    (clk),
    .wr_en  (s1_fire && ctrl.write),
    .wr_addr(s1_addr),
    .wr_data(rec_next),
    .rd_en  (in_acc),
    .rd_addr(in_addr),
    .rd_data(rd_data)
  );

  assign s1_rec = byp_valid ? byp_rec : pixel_rec_t'(rd_data);

  lbspcd_update u_update (
    .rec     (s1_rec),
    .word    (s1_word),
    .cfg     (cfg),
    .pix_zero(s1_addr == '0),
    .rec_next(rec_next),
    .ctrl    (ctrl)
  );

  always_comb begin
    if (ctrl.count_clear) begin
      stable_total_next = '0;
    end else begin
      stable_total_next = stable_total + COUNT_W'(ctrl.count_up);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_valid <= 1'b0;
      out_valid <= 1'b0;
      stable_total <= '0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
        byp_valid <= s1_fire && ctrl.write && (s1_addr == in_addr);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
        stable_total <= stable_total_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word <= in_data;
      s1_addr <= in_addr;
      byp_rec <= rec_next;
    end
    if (s1_fire) begin
      out_data.foreground <= ctrl.foreground;
      out_data.trained_count <= stable_total_next;
      out_data.model_incomplete <= (stable_total_next != frame_pixels);
    end
  end

endmodule

FILE: design/lbspcd_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the change detector top level and their bind.
module lbspcd_checker
  import lbspcd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input in_word_t    in_data,
  input logic        out_valid,
  input logic        out_stall,
  input out_word_t   out_data,
  input logic        cfg_wr_en,
  input logic [1:0]  cfg_addr,
  input logic [17:0] cfg_data
);

  // A waiting result word holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  // The input side stalls only when a result word is waiting and blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output side was free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // A load of pixel zero clears the trained count and reports background.
  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.cmd == CMD_LOAD && in_data.pixel_index == '0)
    ##1 (!out_valid || !out_stall)
    |=> out_valid && out_data.trained_count == '0 && !out_data.foreground)
    else $error("load of pixel zero did not clear the trained count");

endmodule

bind lbsp_change_detect_bg_train_top lbspcd_checker u_checker (.*);
